### rtl/bss_pkg.sv
// Package for the brake self-test sequencer.
// Holds phase and command codes, register indexes and the structs shared by
// the configuration, step and top-level modules. No dependencies.
package bss_pkg;

  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_CHARGED = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EMPTY   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FAKE    = 3'd4;

  localparam logic [CFG_W-1:0] CHARGED_RESET = 16'd1536;
  localparam logic [CFG_W-1:0] EMPTY_RESET   = 16'd256;
  localparam logic [CFG_W-1:0] GAP_RESET     = 16'd1000;

  typedef enum logic [3:0] {
    PH_START    = 4'd0,
    PH_WAITLOW  = 4'd1,
    PH_PRESSURE = 4'd2,
    PH_WAITTS   = 4'd3,
    PH_ACT1     = 4'd4,
    PH_GAP      = 4'd5,
    PH_ACT2     = 4'd6,
    PH_FAILED   = 4'd7,
    PH_DONE     = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    FN_STEP    = 2'd0,
    FN_RESTART = 2'd1,
    FN_FIRE    = 2'd2,
    FN_RELEASE = 2'd3
  } func_t;

  typedef struct packed {
    logic [CFG_W-1:0] charged_threshold;
    logic [CFG_W-1:0] empty_threshold;
    logic [CFG_W-1:0] gap_wait_ms;
    logic             skip_selftest;
    logic             fake_sensors;
  } cfg_t;

  typedef struct packed {
    phase_t phase;
    logic   drive_one;
    logic   drive_two;
    logic   close_latch;
  } ctl_t;

  typedef struct packed {
    logic [3:0] phase;
    logic       checks_ok;
    logic       safe_manual;
    logic       release_one;
    logic       release_two;
    logic       circuit_close;
  } res_t;

endpackage

### rtl/bss_cfg_regs.sv
// Configuration register bank of the brake self-test sequencer.
// Depends on bss_pkg for register indexes, reset values and cfg_t.
module bss_cfg_regs
  import bss_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output cfg_t                 cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_CHARGED: cfg_nxt.charged_threshold = cfg_wdata;
        CFG_EMPTY:   cfg_nxt.empty_threshold   = cfg_wdata;
        CFG_GAP:     cfg_nxt.gap_wait_ms       = cfg_wdata;
        CFG_SKIP:    cfg_nxt.skip_selftest     = cfg_wdata[0];
        CFG_FAKE:    cfg_nxt.fake_sensors      = cfg_wdata[0];
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.charged_threshold <= CHARGED_RESET;
      cfg_r.empty_threshold   <= EMPTY_RESET;
      cfg_r.gap_wait_ms       <= GAP_RESET;
      cfg_r.skip_selftest     <= 1'b0;
      cfg_r.fake_sensors      <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/bss_step.sv
// Combinational step logic: next phase, actuator drives, close latch, mark
// time and the result item for one registered input. Depends on bss_pkg.
module bss_step
  import bss_pkg::*;
#(
  parameter int unsigned TIME_BITS     = 32,
  parameter int unsigned PRESSURE_BITS = 16
) (
  input  cfg_t                     cfg,
  input  ctl_t                     ctl,
  input  logic [TIME_BITS-1:0]     mark,
  input  logic [1:0]               func,
  input  logic [TIME_BITS-1:0]     now_ms,
  input  logic [PRESSURE_BITS-1:0] tank_one_pressure,
  input  logic [PRESSURE_BITS-1:0] tank_two_pressure,
  input  logic                     master_switch_on,
  input  logic                     tractive_active,
  input  logic                     brake_over_limit,
  output ctl_t                     ctl_nxt,
  output logic [TIME_BITS-1:0]     mark_nxt,
  output res_t                     res
);

  // Thresholds are taken in PRESSURE_BITS bits, the gap time in TIME_BITS bits: zero-extended or truncated.
  logic [PRESSURE_BITS+CFG_W-1:0] charged_wide;
  logic [PRESSURE_BITS+CFG_W-1:0] empty_wide;
  logic [TIME_BITS+CFG_W-1:0]     gap_wide;
  logic [PRESSURE_BITS-1:0]       charged_th;
  logic [PRESSURE_BITS-1:0]       empty_th;
  logic [TIME_BITS-1:0]           gap_th;
  logic [TIME_BITS-1:0]           elapsed;
  logic                           charged;
  logic                           empty;
  logic                           line_ok;
  logic                           stepping;
  phase_t                         phase_nxt;

  assign charged_wide = {{PRESSURE_BITS{1'b0}}, cfg.charged_threshold};
  assign empty_wide   = {{PRESSURE_BITS{1'b0}}, cfg.empty_threshold};
  assign gap_wide     = {{TIME_BITS{1'b0}}, cfg.gap_wait_ms};
  assign charged_th   = charged_wide[PRESSURE_BITS-1:0];
  assign empty_th     = empty_wide[PRESSURE_BITS-1:0];
  assign gap_th       = gap_wide[TIME_BITS-1:0];

  assign elapsed  = now_ms - mark;
  assign charged  = cfg.fake_sensors ||
                    ((tank_one_pressure > charged_th) && (tank_two_pressure > charged_th));
  assign empty    = (tank_one_pressure < empty_th) && (tank_two_pressure < empty_th);
  assign line_ok  = cfg.fake_sensors || brake_over_limit;
  assign stepping = (func == FN_STEP) && !cfg.skip_selftest;

  // Next phase.
  always_comb begin
    phase_nxt = ctl.phase;
    case (func)
      FN_STEP: begin
        if (cfg.skip_selftest) begin
          phase_nxt = PH_DONE;
        end else begin
          unique case (ctl.phase)
            PH_START:    phase_nxt = PH_WAITLOW;
            PH_WAITLOW:  phase_nxt = PH_PRESSURE;
            PH_PRESSURE: phase_nxt = charged ? PH_WAITTS : PH_FAILED;
            PH_WAITTS: begin
              if (master_switch_on && tractive_active) phase_nxt = PH_ACT1;
            end
            PH_ACT1: begin
              if (line_ok) phase_nxt = PH_GAP;
            end
            PH_GAP: begin
              if (elapsed > gap_th) phase_nxt = PH_ACT2;
            end
            PH_ACT2: begin
              if (line_ok) phase_nxt = PH_DONE;
            end
            default: phase_nxt = ctl.phase;
          endcase
        end
      end
      FN_RESTART: phase_nxt = PH_START;
      default:    phase_nxt = ctl.phase;
    endcase
  end

  // Drives, close latch, mark time and the result item.
  always_comb begin
    ctl_nxt       = ctl;
    ctl_nxt.phase = phase_nxt;
    mark_nxt      = mark;
    case (func)
      FN_STEP: begin
        if (stepping) begin
          unique case (ctl.phase)
            PH_PRESSURE: begin
              if (charged) begin
                ctl_nxt.close_latch = 1'b1;
                mark_nxt            = now_ms;
              end
            end
            PH_WAITTS: begin
              if (master_switch_on && tractive_active) ctl_nxt.drive_one = 1'b0;
            end
            PH_ACT1: begin
              if (line_ok) begin
                ctl_nxt.drive_one = 1'b1;
                mark_nxt          = now_ms;
              end
            end
            PH_GAP: begin
              if (elapsed > gap_th) ctl_nxt.drive_two = 1'b0;
            end
            PH_ACT2: begin
              if (line_ok) ctl_nxt.drive_two = 1'b1;
            end
            default: ctl_nxt.close_latch = ctl.close_latch;
          endcase
        end
      end
      FN_FIRE: begin
        ctl_nxt.drive_one = 1'b0;
        ctl_nxt.drive_two = 1'b0;
      end
      default: begin
        ctl_nxt.drive_one = 1'b1;
        ctl_nxt.drive_two = 1'b1;
      end
    endcase

    res.phase         = phase_nxt;
    res.checks_ok     = (phase_nxt == PH_DONE) && charged;
    res.safe_manual   = empty;
    res.release_one   = ctl_nxt.drive_one;
    res.release_two   = ctl_nxt.drive_two;
    res.circuit_close = ctl_nxt.close_latch;
  end

endmodule

### rtl/brake_selftest_sequencer_top.sv
// Top level of the brake self-test sequencer: input register, step logic,
// sequencer state and result register. Depends on bss_pkg, bss_cfg_regs, bss_step.
//
//   Channel | Ports                        | Moves
//   --------+------------------------------+--------------------------------
//   in      | in_valid, in_stall, in_*     | one command with time and flags
//   out     | out_valid, out_stall, out_*  | one result per command
//   cfg     | cfg_we, cfg_index, cfg_wdata | register write, no read-back
//
// An item is registered on transfer; when it moves on, the step logic updates the
// sequencer state and loads the result register, which then offers the result.
// With no result stall, one item per cycle is sustained. Reset is synchronous and
// returns the sequencer to the start phase with the registers at their defaults.
// A stalled result holds the input register, which then stalls the input channel.
module brake_selftest_sequencer_top
  import bss_pkg::*;
#(
  parameter int unsigned TIME_BITS     = 32,
  parameter int unsigned PRESSURE_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_func,
  input  logic [TIME_BITS-1:0]     in_now_ms,
  input  logic [PRESSURE_BITS-1:0] in_tank_one_pressure,
  input  logic [PRESSURE_BITS-1:0] in_tank_two_pressure,
  input  logic                     in_master_switch_on,
  input  logic                     in_tractive_active,
  input  logic                     in_brake_over_limit,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [3:0]               out_phase,
  output logic                     out_checks_ok,
  output logic                     out_safe_manual,
  output logic                     out_release_one,
  output logic                     out_release_two,
  output logic                     out_circuit_close
);

  cfg_t cfg;

  logic                     s1_valid_r;
  logic [1:0]               func_r;
  logic [TIME_BITS-1:0]     now_r;
  logic [PRESSURE_BITS-1:0] p1_r;
  logic [PRESSURE_BITS-1:0] p2_r;
  logic                     ms_r;
  logic                     ts_r;
  logic                     bol_r;

  ctl_t                 ctl_r;
  ctl_t                 ctl_nxt;
  logic [TIME_BITS-1:0] mark_r;
  logic [TIME_BITS-1:0] mark_nxt;
  res_t                 res_nxt;
  res_t                 res_r;
  logic                 out_valid_r;
  logic                 s1_adv;
  logic                 in_take;

  bss_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bss_step #(
    .TIME_BITS     (TIME_BITS),
    .PRESSURE_BITS (PRESSURE_BITS)
  ) u_step (
    .cfg               (cfg),
    .ctl               (ctl_r),
    .mark              (mark_r),
    .func              (func_r),
    .now_ms            (now_r),
    .tank_one_pressure (p1_r),
    .tank_two_pressure (p2_r),
    .master_switch_on  (ms_r),
    .tractive_active   (ts_r),
    .brake_over_limit  (bol_r),
    .ctl_nxt           (ctl_nxt),
    .mark_nxt          (mark_nxt),
    .res               (res_nxt)
  );

  // The registered item moves on when the result register is free or draining.
  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      func_r <= in_func;
      now_r  <= in_now_ms;
      p1_r   <= in_tank_one_pressure;
      p2_r   <= in_tank_two_pressure;
      ms_r   <= in_master_switch_on;
      ts_r   <= in_tractive_active;
      bol_r  <= in_brake_over_limit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.phase       <= PH_START;
      ctl_r.drive_one   <= 1'b0;
      ctl_r.drive_two   <= 1'b0;
      ctl_r.close_latch <= 1'b0;
      mark_r            <= '0;
      out_valid_r       <= 1'b0;
    end else begin
      if (s1_adv) begin
        ctl_r  <= ctl_nxt;
        mark_r <= mark_nxt;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_phase         = res_r.phase;
  assign out_checks_ok     = res_r.checks_ok;
  assign out_safe_manual   = res_r.safe_manual;
  assign out_release_one   = res_r.release_one;
  assign out_release_two   = res_r.release_two;
  assign out_circuit_close = res_r.circuit_close;

`ifndef SYNTHESIS
  // A full input register with no output stall always yields a result next cycle.
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_stall) |=> out_valid)
    else $error("registered item did not reach the result register");

  // The ready flag is only reported in the done phase.
  a_ok_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_checks_ok) |-> (out_phase == PH_DONE))
    else $error("checks_ok outside the done phase");

  // The close latch only sets on a step out of the pressure check.
  a_close_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ctl_r.close_latch) |-> ($past(ctl_r.phase) == PH_PRESSURE))
    else $error("close latch set outside the pressure check");

  // The sequencer state only changes when the registered item moves on.
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_adv |=> $stable(ctl_r))
    else $error("sequencer state changed without a transfer");
`endif

endmodule

### tb/sv/brake_selftest_sequencer_top_tb.sv
// Self-checking testbench for brake_selftest_sequencer_top. It predicts every result
// from its own model of the sequencer and compares the results in order, under random stalls.
// Depends on bss_pkg and the RTL of brake_selftest_sequencer_top.
`timescale 1ns / 1ps

module brake_selftest_sequencer_top_tb
  import bss_pkg::*;
();

  localparam int unsigned TIME_W    = 32;
  localparam int unsigned PRES_W    = 16;
  localparam int          WDOG_LIMIT = 4000;
  localparam int          MAX_REPORTS = 10;

  typedef struct packed {
    func_t             func;
    logic [TIME_W-1:0] now_ms;
    logic [PRES_W-1:0] tank_one;
    logic [PRES_W-1:0] tank_two;
    logic              master_on;
    logic              ts_active;
    logic              over_limit;
  } brake_cmd_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           in_func = '0;
  logic [TIME_W-1:0]    in_now_ms = '0;
  logic [PRES_W-1:0]    in_tank_one_pressure = '0;
  logic [PRES_W-1:0]    in_tank_two_pressure = '0;
  logic                 in_master_switch_on = 1'b0;
  logic                 in_tractive_active = 1'b0;
  logic                 in_brake_over_limit = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [3:0]           out_phase;
  logic                 out_checks_ok;
  logic                 out_safe_manual;
  logic                 out_release_one;
  logic                 out_release_two;
  logic                 out_circuit_close;

  brake_selftest_sequencer_top #(
    .TIME_BITS    (TIME_W),
    .PRESSURE_BITS(PRES_W)
  ) dut (.*);

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Sequencer model: configuration copy and state.
  logic [CFG_W-1:0]  lim_charged = CHARGED_RESET;
  logic [CFG_W-1:0]  lim_empty = EMPTY_RESET;
  logic [CFG_W-1:0]  gap_ms = GAP_RESET;
  logic              skip_on = 1'b0;
  logic              fake_on = 1'b0;
  phase_t            seq_phase = PH_START;
  logic [TIME_W-1:0] gap_mark = '0;
  logic              drive_one = 1'b0;
  logic              drive_two = 1'b0;
  logic              close_req = 1'b0;

  brake_cmd_t        pending_cmds[$];
  res_t              expected_reports[$];
  brake_cmd_t        on_wire;
  brake_cmd_t        next_cmd;
  res_t              seen;
  res_t              want;
  int                mismatch_count = 0;
  int                quiet_cycles = 0;
  int                send_idle_pct = 24;
  int                recv_idle_pct = 55;
  logic [TIME_W-1:0] stim_ms = '0;

  function automatic res_t sequencer_next(brake_cmd_t c);
    res_t              r;
    logic [TIME_W-1:0] elapsed;
    logic              charged;
    logic              line_ok;
    charged = fake_on || (c.tank_one > lim_charged && c.tank_two > lim_charged);
    line_ok = fake_on || c.over_limit;
    elapsed = c.now_ms - gap_mark;
    case (c.func)
      FN_STEP: begin
        if (skip_on) begin
          seq_phase = PH_DONE;
        end else begin
          case (seq_phase)
            PH_START:   seq_phase = PH_WAITLOW;
            PH_WAITLOW: seq_phase = PH_PRESSURE;
            PH_PRESSURE: begin
              if (charged) begin
                seq_phase = PH_WAITTS;
                close_req = 1'b1;
                gap_mark = c.now_ms;
              end else begin
                seq_phase = PH_FAILED;
              end
            end
            PH_WAITTS: begin
              if (c.master_on && c.ts_active) begin
                seq_phase = PH_ACT1;
                drive_one = 1'b0;
              end
            end
            PH_ACT1: begin
              if (line_ok) begin
                seq_phase = PH_GAP;
                drive_one = 1'b1;
                gap_mark = c.now_ms;
              end
            end
            PH_GAP: begin
              if (elapsed > TIME_W'(gap_ms)) begin
                seq_phase = PH_ACT2;
                drive_two = 1'b0;
              end
            end
            PH_ACT2: begin
              if (line_ok) begin
                seq_phase = PH_DONE;
                drive_two = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      FN_RESTART: begin
        seq_phase = PH_START;
        drive_one = 1'b1;
        drive_two = 1'b1;
      end
      FN_FIRE: begin
        drive_one = 1'b0;
        drive_two = 1'b0;
      end
      default: begin
        drive_one = 1'b1;
        drive_two = 1'b1;
      end
    endcase
    r.phase         = seq_phase;
    r.checks_ok     = (seq_phase == PH_DONE) && charged;
    r.safe_manual   = (c.tank_one < lim_empty) && (c.tank_two < lim_empty);
    r.release_one   = drive_one;
    r.release_two   = drive_two;
    r.circuit_close = close_req;
    return r;
  endfunction

  // Driver: a new command is offered only when the last one has transferred.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_reports.push_back(sequencer_next(on_wire));
      end
      if (!in_valid || !in_stall) begin
        if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_cmd = pending_cmds.pop_front();
          on_wire = next_cmd;
          in_valid <= 1'b1;
          in_func <= next_cmd.func;
          in_now_ms <= next_cmd.now_ms;
          in_tank_one_pressure <= next_cmd.tank_one;
          in_tank_two_pressure <= next_cmd.tank_two;
          in_master_switch_on <= next_cmd.master_on;
          in_tractive_active <= next_cmd.ts_active;
          in_brake_over_limit <= next_cmd.over_limit;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transfer and drives the result stall.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    if (rst_n && out_valid && !out_stall) begin
      seen = {out_phase, out_checks_ok, out_safe_manual, out_release_one,
              out_release_two, out_circuit_close};
      if (expected_reports.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("[%0t] unexpected result: phase %0d", $realtime, seen.phase);
        end
      end else begin
        want = expected_reports.pop_front();
        if (seen.phase !== want.phase || seen.checks_ok !== want.checks_ok ||
            seen.safe_manual !== want.safe_manual ||
            seen.release_one !== want.release_one ||
            seen.release_two !== want.release_two ||
            seen.circuit_close !== want.circuit_close) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("[%0t] result mismatch (expected/actual): phase %0d/%0d ok %0b/%0b",
                     $realtime, want.phase, seen.phase, want.checks_ok, seen.checks_ok);
            $display("  safe %0b/%0b rel1 %0b/%0b rel2 %0b/%0b close %0b/%0b",
                     want.safe_manual, seen.safe_manual, want.release_one,
                     seen.release_one, want.release_two, seen.release_two,
                     want.circuit_close, seen.circuit_close);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WDOG_LIMIT) begin
      $display("[%0t] watchdog: no transfer for %0d cycles", $realtime, WDOG_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic add_cmd(input func_t f, input logic [TIME_W-1:0] t,
                         input logic [PRES_W-1:0] p1, input logic [PRES_W-1:0] p2,
                         input logic msw, input logic ts, input logic over);
    brake_cmd_t c;
    c = '{f, t, p1, p2, msw, ts, over};
    pending_cmds.push_back(c);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_CHARGED: lim_charged = val;
      CFG_EMPTY:   lim_empty = val;
      CFG_GAP:     gap_ms = val;
      CFG_SKIP:    skip_on = val[0];
      CFG_FAKE:    fake_on = val[0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [CFG_W-1:0] charged, input logic [CFG_W-1:0] empty,
                              input logic [CFG_W-1:0] gap, input logic skip,
                              input logic fake);
    write_reg(CFG_CHARGED, charged);
    write_reg(CFG_EMPTY, empty);
    write_reg(CFG_GAP, gap);
    write_reg(CFG_SKIP, CFG_W'(skip));
    write_reg(CFG_FAKE, CFG_W'(fake));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every command has transferred and every result has been checked.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || in_valid || expected_reports.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Pressures biased toward the charged band so that the pressure check often passes.
  function automatic logic [PRES_W-1:0] pick_pressure(input bit want_high);
    int r;
    if (want_high && lim_charged != '1) begin
      return PRES_W'($urandom_range(int'(lim_charged) + 1, 65535));
    end
    r = $urandom_range(0, 99);
    if (r < 30 && lim_empty != 0) begin
      return PRES_W'($urandom_range(0, int'(lim_empty) - 1));
    end
    if (r < 40) begin
      return lim_charged;
    end
    return PRES_W'($urandom_range(0, 65535));
  endfunction

  function automatic brake_cmd_t shaped_cmd(input func_t f);
    brake_cmd_t c;
    int         r;
    bit         high;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      stim_ms = stim_ms + TIME_W'($urandom_range(0, 70000));
    end else if (r < 13) begin
      stim_ms = $urandom;
    end else begin
      stim_ms = stim_ms + TIME_W'($urandom_range(0, 300));
    end
    high = ($urandom_range(0, 99) < 70);
    c.func = f;
    c.now_ms = stim_ms;
    c.tank_one = pick_pressure(high);
    c.tank_two = pick_pressure(high);
    c.master_on = ($urandom_range(0, 99) < 80);
    c.ts_active = ($urandom_range(0, 99) < 80);
    c.over_limit = ($urandom_range(0, 99) < 65);
    return c;
  endfunction

  // Mostly restart-led step runs with plausible content, plus some pure noise.
  task automatic add_random(input int count);
    int         added;
    int         run_len;
    int         r;
    brake_cmd_t c;
    added = 0;
    while (added < count) begin
      if ($urandom_range(0, 99) < 15) begin
        c.func = func_t'($urandom_range(0, 3));
        c.now_ms = $urandom;
        c.tank_one = PRES_W'($urandom);
        c.tank_two = PRES_W'($urandom);
        c.master_on = 1'($urandom_range(0, 1));
        c.ts_active = 1'($urandom_range(0, 1));
        c.over_limit = 1'($urandom_range(0, 1));
        pending_cmds.push_back(c);
        added++;
      end else begin
        run_len = $urandom_range(6, 18);
        pending_cmds.push_back(shaped_cmd(FN_RESTART));
        for (int k = 0; k < run_len; k++) begin
          r = $urandom_range(0, 99);
          if (r < 90) begin
            pending_cmds.push_back(shaped_cmd(FN_STEP));
          end else if (r < 95) begin
            pending_cmds.push_back(shaped_cmd(FN_FIRE));
          end else begin
            pending_cmds.push_back(shaped_cmd(FN_RELEASE));
          end
        end
        added += run_len + 1;
      end
    end
  endtask

  initial begin
    stim_ms = $urandom;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Full pass through the sequence with the default registers, including a
    // pressure exactly at the threshold, stalled waits and a gap across the time wrap.
    add_cmd(FN_STEP,    32'h0000_0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0);
    add_cmd(FN_STEP,    32'h0000_0010, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0);
    add_cmd(FN_STEP,    32'h0000_0020, 16'd1536, 16'hFFFF, 1'b1, 1'b1, 1'b1);
    add_cmd(FN_STEP,    32'h0000_0030, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1);
    add_cmd(FN_RESTART, 32'h0000_0040, 16'h0100, 16'h0100, 1'b0, 1'b0, 1'b0);
    add_cmd(FN_STEP,    32'h0000_0050, 16'h0100, 16'h0100, 1'b0, 1'b0, 1'b0);
    add_cmd(FN_STEP,    32'h0000_0060, 16'h0100, 16'h0100, 1'b0, 1'b0, 1'b0);
    add_cmd(FN_STEP,    32'hFFFF_FF00, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0);
    add_cmd(FN_STEP,    32'hFFFF_FF00, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 1'b0);
    add_cmd(FN_STEP,    32'hFFFF_FF00, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 1'b0);
    add_cmd(FN_STEP,    32'hFFFF_FF00, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b0);
    add_cmd(FN_STEP,    32'hFFFF_FF00, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b0);
    add_cmd(FN_STEP,    32'hFFFF_FF00, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1);
    add_cmd(FN_STEP,    32'h0000_02E8, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0);
    add_cmd(FN_STEP,    32'h0000_02E9, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0);
    add_cmd(FN_FIRE,    32'h0000_0300, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0);
    add_cmd(FN_RELEASE, 32'h0000_0310, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0);
    add_cmd(FN_STEP,    32'h0000_0320, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0);
    add_cmd(FN_STEP,    32'h0000_0330, 16'h0605, 16'h0700, 1'b0, 1'b0, 1'b1);
    add_cmd(FN_STEP,    32'h0000_0340, 16'h00FF, 16'h00FF, 1'b0, 1'b0, 1'b1);
    add_cmd(FN_STEP,    32'h0000_0350, 16'h0100, 16'h0000, 1'b1, 1'b1, 1'b1);
    add_cmd(FN_RESTART, 32'h0000_0360, 16'h0000, 16'h0000, 1'b1, 1'b1, 1'b1);
    add_cmd(FN_FIRE,    32'h0000_0370, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0);
    add_cmd(FN_RELEASE, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1);
    add_random(90);
    wait_drained();

    program_regs(16'h0000, 16'hFFFF, 16'h0000, 1'b0, 1'b0);
    add_random(100);
    wait_drained();

    send_idle_pct = 55;
    recv_idle_pct = 24;
    program_regs(16'hFFFF, 16'h0000, 16'hFFFF, 1'b0, 1'b1);
    add_random(100);
    wait_drained();

    program_regs(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom_range(0, 3000)),
                 1'b1, 1'($urandom_range(0, 1)));
    add_random(100);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_regs(CFG_W'($urandom_range(0, 16'hF000)), CFG_W'($urandom),
                 CFG_W'($urandom_range(0, 2000)), 1'b0, 1'b0);
    add_random(100);
    wait_drained();

    program_regs(CHARGED_RESET, EMPTY_RESET, GAP_RESET, 1'b0, 1'b1);
    add_random(100);
    wait_drained();

    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && expected_reports.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
